// ===== sv/sbus_frame_decoder_core_assert.svh =====
// Assertion macros used by the RTL of the frame decoder core.
`ifndef SBUS_FRAME_DECODER_CORE_ASSERT_SVH
`define SBUS_FRAME_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, off while reset is held low.
`define SBFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define SBFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SBFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBFD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/sbfd_pkg.sv =====
`default_nettype none

package sbfd_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int NUM_CHANNELS = 16;
    localparam int ADDR_W       = $clog2(FRAME_BYTES);
    localparam int CNT_W        = $clog2(FRAME_BYTES + 1);
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int CHAN_W       = 11;
    localparam int ACC_W        = CHAN_W + 7;
    localparam int NBITS_W      = $clog2(ACC_W + 1);
    localparam int CFG_W        = 10;
    localparam int CFG_IDX_W    = 1;

    // Byte positions inside a frame
    localparam logic [CNT_W-1:0]  START_POS  = CNT_W'(0);
    localparam logic [CNT_W-1:0]  FLAGS_POS  = CNT_W'(23);
    localparam logic [CNT_W-1:0]  END_POS    = CNT_W'(24);
    localparam logic [ADDR_W-1:0] FIRST_DATA = ADDR_W'(1);

    localparam logic [7:0] START_MARK = 8'h0F;
    localparam logic [7:0] END_MARK   = 8'h00;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_SHORT     = 3'd1;
    localparam t_status ST_BAD_START = 3'd2;
    localparam t_status ST_BAD_END   = 3'd3;
    localparam t_status ST_FLAGS     = 3'd4;

    typedef logic [1:0] t_switch;
    localparam t_switch SW_UP     = 2'd0;
    localparam t_switch SW_CENTER = 2'd1;
    localparam t_switch SW_DOWN   = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEADBAND  = 1'b0;
    localparam t_cfg_idx CFG_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] DEADBAND_RST  = CFG_W'(10);
    localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(500);

endpackage

`default_nettype wire

// ===== sv/sbus_frame_decoder_core.sv =====
// SBUS frame decoder. Bytes of a radio-control frame arrive one word per
// handshake on the slave stream, tlast marking the final byte of the received
// buffer; the first 25 bytes go into a small store and any further bytes are
// dropped. On the final byte the block checks length and start byte: a short
// frame or a bad start gives a single error word, loaded through the error
// state into the output register once that is free. A good frame is unpacked
// by one shared bit accumulator that walks bytes 1 to 22 of the store, one RAM
// read per byte through the issue, data and check states, and emits a channel
// word whenever eleven bits are held and the master stream can take it; the
// slave side is not ready while the frame is decoded.
// Each channel word carries the value minus 1024 with the deadband applied,
// the switch position from the threshold and the frame status (flags byte
// nonzero beats end byte not 0x00). Deadband and threshold must be written by
// the user over the configuration channel only while the block is idle; the
// block itself does not enforce it.

`default_nettype none

`include "sbus_frame_decoder_core_assert.svh"

module sbus_frame_decoder_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream: tdata[7:0] data_byte; tlast = last_byte
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    // master stream: tdata[3:0] channel_index, [14:4] channel_value,
    // [16:15] switch_position, [19:17] status, [23:20] zero;
    // tlast = last_result
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [23:0]                     m_axis_tdata,
    output logic                                 m_axis_tlast,
    // configuration: index 0 deadband, index 1 switch_threshold
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sbfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbfd_pkg::CFG_W-1:0]      i_cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ERR   = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_DATA  = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;

    localparam int ADDR_W   = sbfd_pkg::ADDR_W;
    localparam int CNT_W    = sbfd_pkg::CNT_W;
    localparam int CH_W     = sbfd_pkg::CH_IDX_W;
    localparam int CHAN_W   = sbfd_pkg::CHAN_W;
    localparam int ACC_W    = sbfd_pkg::ACC_W;
    localparam int NBITS_W  = sbfd_pkg::NBITS_W;
    localparam int CFG_W    = sbfd_pkg::CFG_W;

    localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(sbfd_pkg::FRAME_BYTES);
    localparam logic [CH_W-1:0]    LAST_CH  = CH_W'(sbfd_pkg::NUM_CHANNELS - 1);
    localparam logic [NBITS_W-1:0] CHAN_NB  = NBITS_W'(CHAN_W);
    localparam logic [NBITS_W-1:0] BYTE_NB  = NBITS_W'(8);

    // Control state
    logic [2:0]            r_state;
    logic [CNT_W-1:0]      r_byte_cnt;
    logic [NBITS_W-1:0]    r_nbits;
    logic                  r_m_valid;
    logic [CFG_W-1:0]      r_deadband;
    logic [CFG_W-1:0]      r_threshold;

    // Datapath state
    logic                  r_start_ok;
    logic                  r_flags_nz;
    logic                  r_end_nz;
    sbfd_pkg::t_status     r_frame_st;
    sbfd_pkg::t_status     r_err_st;
    logic [ADDR_W-1:0]     r_addr;
    logic [CH_W-1:0]       r_ch;
    logic [ACC_W-1:0]      r_acc;

    // Output word
    logic [CH_W-1:0]       r_o_idx;
    logic signed [CHAN_W-1:0] r_o_val;
    sbfd_pkg::t_switch     r_o_sw;
    sbfd_pkg::t_status     r_o_st;
    logic                  r_o_last;

    logic                  w_in_acc;
    logic                  w_store;
    logic [CNT_W-1:0]      w_cnt_inc;
    logic                  w_out_free;
    logic                  w_ram_re;
    logic [7:0]            w_rdata;
    logic                  w_end_nz;

    logic [CHAN_W-1:0]     w_raw;
    logic signed [CHAN_W-1:0] w_v;
    logic signed [CHAN_W:0]   w_v12;
    logic signed [CHAN_W:0]   w_db12;
    logic signed [CHAN_W:0]   w_th12;
    logic signed [CHAN_W:0]   w_vz;
    sbfd_pkg::t_switch     w_sw;
    logic                  w_emit;
    logic                  w_err_load;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_store       = w_in_acc && (r_byte_cnt < FULL_CNT);
    assign w_cnt_inc     = w_store ? (r_byte_cnt + CNT_W'(1)) : r_byte_cnt;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_ram_re      = (r_state == S_ISSUE);

    // The end byte may be the final byte itself: take it straight off the bus then.
    assign w_end_nz = (w_store && (r_byte_cnt == sbfd_pkg::END_POS))
                    ? (s_axis_tdata != sbfd_pkg::END_MARK) : r_end_nz;

    sbfd_ram #(
        .WIDTH(8),
        .DEPTH(sbfd_pkg::FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_byte_cnt[ADDR_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (w_ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Channel arithmetic: centre by flipping the top bit, then deadband and
    // switch compares in one bit more so that -1024 and -threshold fit.
    assign w_raw  = r_acc[CHAN_W-1:0];
    assign w_v    = $signed({~w_raw[CHAN_W-1], w_raw[CHAN_W-2:0]});
    assign w_v12  = {w_v[CHAN_W-1], w_v};
    assign w_db12 = $signed({2'b00, r_deadband});
    assign w_th12 = $signed({2'b00, r_threshold});

    always_comb begin
        w_vz = w_v12;
        if ((w_v12 <= w_db12) && (w_v12 >= -w_db12)) begin
            w_vz = '0;
        end
        if (w_vz > w_th12) begin
            w_sw = sbfd_pkg::SW_DOWN;
        end else if (w_vz < -w_th12) begin
            w_sw = sbfd_pkg::SW_UP;
        end else begin
            w_sw = sbfd_pkg::SW_CENTER;
        end
    end

    assign w_emit     = (r_state == S_CHK) && (r_nbits >= CHAN_NB) && w_out_free;
    assign w_err_load = (r_state == S_ERR) && w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband  <= sbfd_pkg::DEADBAND_RST;
            r_threshold <= sbfd_pkg::THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sbfd_pkg::CFG_DEADBAND:  r_deadband  <= i_cfg_data;
                sbfd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_byte_cnt <= '0;
            r_nbits    <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (w_emit || w_err_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tlast) begin
                            // the frame ends here: restart the count
                            r_byte_cnt <= '0;
                            r_nbits    <= '0;
                            if ((w_cnt_inc < FULL_CNT) || !r_start_ok) begin
                                r_state <= S_ERR;
                            end else begin
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_byte_cnt <= w_cnt_inc;
                        end
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    r_nbits <= r_nbits + BYTE_NB;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_nbits >= CHAN_NB) begin
                        if (w_out_free) begin
                            r_nbits <= r_nbits - CHAN_NB;
                            r_state <= (r_ch == LAST_CH) ? S_IDLE : S_ISSUE;
                        end
                    end else begin
                        r_state <= S_ISSUE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Frame markers, captured as the bytes are stored
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            if (r_byte_cnt == sbfd_pkg::START_POS) begin
                r_start_ok <= (s_axis_tdata == sbfd_pkg::START_MARK);
            end
            if (r_byte_cnt == sbfd_pkg::FLAGS_POS) begin
                r_flags_nz <= (s_axis_tdata != 8'h00);
            end
            if (r_byte_cnt == sbfd_pkg::END_POS) begin
                r_end_nz <= (s_axis_tdata != sbfd_pkg::END_MARK);
            end
        end
    end

    // Decode datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_in_acc && s_axis_tlast) begin
            r_addr   <= sbfd_pkg::FIRST_DATA;
            r_ch     <= '0;
            r_acc    <= '0;
            r_err_st <= (w_cnt_inc < FULL_CNT) ? sbfd_pkg::ST_SHORT
                                               : sbfd_pkg::ST_BAD_START;
            if (r_flags_nz) begin
                r_frame_st <= sbfd_pkg::ST_FLAGS;
            end else if (w_end_nz) begin
                r_frame_st <= sbfd_pkg::ST_BAD_END;
            end else begin
                r_frame_st <= sbfd_pkg::ST_OK;
            end
        end
        if (r_state == S_DATA) begin
            // append the fresh byte above the bits still held
            r_acc  <= r_acc | (ACC_W'(w_rdata) << r_nbits);
            r_addr <= r_addr + ADDR_W'(1);
        end
        if (w_emit) begin
            r_acc <= r_acc >> CHAN_W;
            r_ch  <= r_ch + CH_W'(1);
        end
    end

    // Output register: load a channel or an error word
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_idx  <= r_ch;
            r_o_val  <= w_vz[CHAN_W-1:0];
            r_o_sw   <= w_sw;
            r_o_st   <= r_frame_st;
            r_o_last <= (r_ch == LAST_CH);
        end else if (w_err_load) begin
            r_o_idx  <= '0;
            r_o_val  <= '0;
            r_o_sw   <= sbfd_pkg::SW_CENTER;
            r_o_st   <= r_err_st;
            r_o_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_o_st, r_o_sw, r_o_val, r_o_idx};
    assign m_axis_tlast  = r_o_last;

    // Count restarts on every final byte, so it is zero while decoding.
    `SBFD_ASSERT(a_cnt_idle_decode, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> (r_byte_cnt == '0), "byte count not cleared for decode")
    `SBFD_ASSERT(a_cnt_bound, i_clk, i_rst_n,
        r_byte_cnt <= FULL_CNT, "byte count beyond frame length")
    `SBFD_ASSERT(a_acc_bound, i_clk, i_rst_n,
        r_nbits <= NBITS_W'(ACC_W), "bit accumulator overfilled")
    `SBFD_ASSERT(a_err_word, i_clk, i_rst_n,
        (m_axis_tvalid && ((r_o_st == sbfd_pkg::ST_SHORT) ||
        (r_o_st == sbfd_pkg::ST_BAD_START))) |-> (m_axis_tlast && (r_o_idx == '0)
        && (r_o_val == '0)), "malformed error word")
    `SBFD_ASSERT(a_last_channel, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tlast && (r_o_st != sbfd_pkg::ST_SHORT) &&
        (r_o_st != sbfd_pkg::ST_BAD_START)) |-> (r_o_idx == LAST_CH),
        "frame closed before last channel")

endmodule

`default_nettype wire

// ===== sv/sbfd_ram.sv =====
`default_nettype none

module sbfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
